[rtl/assert_macros.svh]
// Assertion helpers used by psd_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/psd_pkg.sv]
package psd_pkg;

    localparam int MAX_UNITS = 64;
    localparam int IDX_W     = $clog2(MAX_UNITS);
    localparam int CNT_W     = $clog2(MAX_UNITS + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        CMD_WORKER = 2'd0,
        CMD_LEADER = 2'd1,
        CMD_CLEAR  = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        MODE_RESTART   = 2'd0,
        MODE_AT        = 2'd1,
        MODE_EXHAUSTED = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_COUNT     = 3'd0,
        CFG_USE_VALID_MASK = 3'd1,
        CFG_VALID_MASK     = 3'd2,
        CFG_FIRST_PARTIAL  = 3'd3,
        CFG_LEADER         = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AFTER,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic scan;
        logic after;
        logic emit;
    } dsp_cmd_t;

    typedef struct packed {
        logic direct;
        logic scan_found;
        logic scan_fail;
        logic after_end;
        logic out_free;
    } dsp_sts_t;

endpackage

[rtl/psd_ctrl.sv]
`include "assert_macros.svh"

module psd_ctrl
    import psd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  dsp_sts_t  sts,
    output dsp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.direct ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_fail)
                begin
                    state_next = ST_EMIT;
                end
                else if (sts.scan_found)
                begin
                    state_next = ST_AFTER;
                end
            end
            ST_AFTER:
            begin
                if (sts.after_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.take  = req_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_AFTER:
            begin
                cmd.after = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_NEXT(a_take_leaves_idle, clk, rst_n, cmd.take, state_reg != ST_IDLE, "item completed in accept cycle")
    `ASSERT_IMPLIES(a_emit_needs_room, clk, rst_n, cmd.emit, sts.out_free, "result loaded over pending item")
    `ASSERT_NEXT(a_scan_holds, clk, rst_n, state_reg == ST_SCAN && !sts.scan_found && !sts.scan_fail, state_reg == ST_SCAN, "scan left without an outcome")

endmodule

[rtl/psd_dp.sv]
module psd_dp
    import psd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dsp_cmd_t              cmd,
    output dsp_sts_t              sts,
    input  logic [1:0]            command,
    input  logic                  done_valid,
    input  logic [IDX_W-1:0]      done_index,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [IDX_W-1:0]      assigned_index,
    output logic                  none_left,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CNT_W-1:0]     unit_count_reg;
    logic                 use_mask_reg;
    logic [MAX_UNITS-1:0] valid_mask_reg;
    logic [CNT_W-1:0]     first_partial_reg;
    logic                 leader_reg;

    logic [MAX_UNITS-1:0] marks_reg;
    logic [MAX_UNITS-1:0] marks_next;
    mode_t                mode_reg;
    mode_t                mode_next;
    logic [IDX_W-1:0]     ptr_reg;
    logic [IDX_W-1:0]     ptr_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    logic [IDX_W-1:0]     cur_reg;
    logic [IDX_W-1:0]     cur_next;
    logic [CNT_W-1:0]     k_reg;
    logic [CNT_W-1:0]     k_next;
    logic                 at_start_reg;
    logic                 at_start_next;
    logic [CNT_W-1:0]     after_reg;
    logic [CNT_W-1:0]     after_next;
    logic [IDX_W-1:0]     res_idx_reg;
    logic [IDX_W-1:0]     res_idx_next;
    logic                 res_none_reg;
    logic                 res_none_next;
    logic [IDX_W-1:0]     out_idx_reg;
    logic                 out_none_reg;

    logic [CNT_W-1:0]     cnt_eff;
    logic                 serve;
    logic                 ptr_live;
    logic [CNT_W-1:0]     cur_inc;
    logic                 scan_hit;
    logic                 scan_fail;
    logic                 after_elig;
    logic                 after_past;

    function automatic logic eligible(
        input logic [CNT_W-1:0]     pos,
        input logic [CNT_W-1:0]     cnt,
        input logic                 use_mask,
        input logic [MAX_UNITS-1:0] mask
    );
        eligible = (pos < cnt) && (!use_mask || mask[pos[IDX_W-1:0]]);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_count_reg    <= '0;
            use_mask_reg      <= 1'b0;
            valid_mask_reg    <= '0;
            first_partial_reg <= '0;
            leader_reg        <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_UNIT_COUNT:     unit_count_reg    <= cfg_data[CNT_W-1:0];
                CFG_USE_VALID_MASK: use_mask_reg      <= cfg_data[0];
                CFG_VALID_MASK:     valid_mask_reg    <= cfg_data[MAX_UNITS-1:0];
                CFG_FIRST_PARTIAL:  first_partial_reg <= cfg_data[CNT_W-1:0];
                CFG_LEADER:         leader_reg        <= cfg_data[0];
                default:            leader_reg        <= leader_reg;
            endcase
        end
    end

    assign cnt_eff = (unit_count_reg > CNT_W'(MAX_UNITS)) ? CNT_W'(MAX_UNITS) : unit_count_reg;
    assign serve   = (command == CMD_WORKER) || ((command == CMD_LEADER) && leader_reg);
    assign ptr_live = (mode_reg == MODE_AT) && ({1'b0, ptr_reg} < cnt_eff);

    assign cur_inc   = {1'b0, cur_reg} + CNT_W'(1);
    assign scan_fail = (k_reg == cnt_eff);
    assign scan_hit  = !marks_reg[cur_reg]
                       && (eligible({1'b0, cur_reg}, cnt_eff, use_mask_reg, valid_mask_reg)
                           || ((k_reg == '0) && at_start_reg));
    assign after_past = (after_reg >= cnt_eff);
    assign after_elig = eligible(after_reg, cnt_eff, use_mask_reg, valid_mask_reg);

    assign sts.direct     = !serve || (mode_reg == MODE_EXHAUSTED);
    assign sts.scan_found = !scan_fail && scan_hit;
    assign sts.scan_fail  = scan_fail;
    assign sts.after_end  = after_past || after_elig;
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        marks_next    = marks_reg;
        mode_next     = mode_reg;
        ptr_next      = ptr_reg;
        cur_next      = cur_reg;
        k_next        = k_reg;
        at_start_next = at_start_reg;
        after_next    = after_reg;
        res_idx_next  = res_idx_reg;
        res_none_next = res_none_reg;

        if (cmd.take)
        begin
            if (serve && done_valid && ({1'b0, done_index} < CNT_W'(MAX_UNITS)))
            begin
                marks_next[done_index] = 1'b1;
            end
            if (command == CMD_CLEAR)
            begin
                marks_next = '0;
                mode_next  = MODE_RESTART;
                ptr_next   = '0;
            end
            res_idx_next  = '0;
            res_none_next = 1'b1;
            cur_next      = ptr_live ? ptr_reg : '0;
            k_next        = '0;
            at_start_next = ptr_live;
        end

        if (cmd.scan)
        begin
            if (scan_fail)
            begin
                mode_next     = MODE_EXHAUSTED;
                res_idx_next  = '0;
                res_none_next = 1'b1;
            end
            else if (scan_hit)
            begin
                res_idx_next  = cur_reg;
                res_none_next = 1'b0;
                after_next    = cur_inc;
                if ({1'b0, cur_reg} < first_partial_reg)
                begin
                    marks_next[cur_reg] = 1'b1;
                end
            end
            else
            begin
                cur_next = (cur_inc == cnt_eff) ? '0 : cur_inc[IDX_W-1:0];
                k_next   = k_reg + CNT_W'(1);
            end
        end

        if (cmd.after)
        begin
            if (after_past)
            begin
                mode_next = MODE_RESTART;
                ptr_next  = '0;
            end
            else if (after_elig)
            begin
                mode_next = MODE_AT;
                ptr_next  = after_reg[IDX_W-1:0];
            end
            else
            begin
                after_next = after_reg + CNT_W'(1);
            end
        end
    end

    assign rsp_valid_next = cmd.emit || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg     <= '0;
            mode_reg      <= MODE_RESTART;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            marks_reg     <= marks_next;
            mode_reg      <= mode_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        k_reg        <= k_next;
        at_start_reg <= at_start_next;
        after_reg    <= after_next;
        res_idx_reg  <= res_idx_next;
        res_none_reg <= res_none_next;
        if (cmd.emit)
        begin
            out_idx_reg  <= res_idx_reg;
            out_none_reg <= res_none_reg;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign assigned_index = out_idx_reg;
    assign none_left      = out_none_reg;

endmodule

[rtl/parallel_subplan_dispatcher.sv]
// Work-unit dispatcher for parallel workers.
// Request channel (req_valid / req_stall): command, done_valid, done_index.
// An item is taken when req_valid is high and req_stall is low. Worker and
// served leader requests record the reported finished unit, then search.
// Response channel (rsp_valid / rsp_stall): assigned_index, none_left, one
// item per request, in order. The response sits in an output register and
// holds while rsp_stall is high; the next request is not taken until the
// current one has been placed in that register.
// Clear, unused and unserved leader commands, and requests once the pointer
// is exhausted, go from the accept state straight to the emit state. A search
// walks the finished marks one unit a cycle, then walks to the next eligible
// unit for the pointer before the emit state; a search that finds nothing
// goes to the emit state once every unit has been passed.
// A new request can be taken in the cycle after its predecessor's response
// is loaded; requests are not overlapped.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; write only while no request is in flight.
// Reset (rst_n low, asynchronous): state, configuration and marks clear,
// pointer restarts at unit 0, no response pending; data regs are not reset.
module parallel_subplan_dispatcher
    import psd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            command,
    input  logic                  done_valid,
    input  logic [IDX_W-1:0]      done_index,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [IDX_W-1:0]      assigned_index,
    output logic                  none_left,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dsp_cmd_t cmd;
    dsp_sts_t sts;

    assign cfg_ready = 1'b1;

    psd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    psd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .command        (command),
        .done_valid     (done_valid),
        .done_index     (done_index),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .assigned_index (assigned_index),
        .none_left      (none_left),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

endmodule

[tb/parallel_subplan_dispatcher_test.sv]
module parallel_subplan_dispatcher_test;
    import psd_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int QUIET_ITEMS = 150;
    localparam int DRAIN_CYCLES = 140;

    typedef struct packed {
        logic [IDX_W-1:0] unit;
        logic             none;
    } grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic [1:0]            command = CMD_WORKER;
    logic                  done_valid = 1'b0;
    logic [IDX_W-1:0]      done_index = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic [IDX_W-1:0]      assigned_index;
    logic                  none_left;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_UNIT_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [6:0]            cfg_unit_count = '0;
    logic                  cfg_use_mask = 1'b0;
    logic [MAX_UNITS-1:0]  cfg_mask = '0;
    logic [6:0]            cfg_first_partial = '0;
    logic                  cfg_leader = 1'b0;
    logic [MAX_UNITS-1:0]  unit_marks = '0;
    mode_t                 ptr_mode = MODE_RESTART;
    logic [IDX_W-1:0]      ptr_index = '0;

    grant_t expected_grants[$];
    int     errors = 0;
    int     items_sent = 0;
    int     cycles = 0;
    bit     quiet = 1'b0;
    bit     hold_request = 1'b0;
    int     hold_left = 0;
    int     burst_left = 0;

    parallel_subplan_dispatcher i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .command        (command),
        .done_valid     (done_valid),
        .done_index     (done_index),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .assigned_index (assigned_index),
        .none_left      (none_left),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int active_units();
        return (cfg_unit_count > MAX_UNITS) ? MAX_UNITS : int'(cfg_unit_count);
    endfunction

    function automatic int next_eligible_unit(int last);
        int i;
        for (i = last + 1; i < active_units(); i++)
        begin
            if (!cfg_use_mask || cfg_mask[i])
                return i;
        end
        return -1;
    endfunction

    function automatic int serve_unit(logic dv, logic [IDX_W-1:0] di);
        int nxt;
        int origin;
        int steps;
        int following;
        if (dv)
            unit_marks[di] = 1'b1;
        if (ptr_mode == MODE_EXHAUSTED)
            return -1;
        if (ptr_mode == MODE_AT && int'(ptr_index) < active_units())
            nxt = int'(ptr_index);
        else
            nxt = next_eligible_unit(-1);
        if (nxt < 0)
        begin
            ptr_mode = MODE_EXHAUSTED;
            return -1;
        end
        origin = nxt;
        steps = 0;
        while (unit_marks[nxt])
        begin
            nxt = next_eligible_unit(nxt);
            if (nxt < 0)
                nxt = next_eligible_unit(-1);
            steps++;
            if (nxt < 0 || nxt == origin || steps > MAX_UNITS)
            begin
                ptr_mode = MODE_EXHAUSTED;
                return -1;
            end
        end
        if (nxt < int'(cfg_first_partial))
            unit_marks[nxt] = 1'b1;
        following = next_eligible_unit(nxt);
        if (following < 0)
        begin
            ptr_mode = MODE_RESTART;
            ptr_index = '0;
        end
        else
        begin
            ptr_mode = MODE_AT;
            ptr_index = following[IDX_W-1:0];
        end
        return nxt;
    endfunction

    function automatic grant_t grant_for_request(logic [1:0] cmd, logic dv,
                                                 logic [IDX_W-1:0] di);
        int unit;
        grant_t g;
        unit = -1;
        case (cmd)
            CMD_WORKER: unit = serve_unit(dv, di);
            CMD_LEADER: if (cfg_leader) unit = serve_unit(dv, di);
            CMD_CLEAR:
            begin
                unit_marks = '0;
                ptr_mode = MODE_RESTART;
                ptr_index = '0;
            end
            default: ;
        endcase
        if (unit < 0)
        begin
            g.unit = '0;
            g.none = 1'b1;
        end
        else
        begin
            g.unit = unit[IDX_W-1:0];
            g.none = 1'b0;
        end
        return g;
    endfunction

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: unexpected item unit %0d none_left %0b",
                         $time, assigned_index, none_left);
                errors++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (assigned_index !== want.unit)
                begin
                    $display("%0t: assigned_index expected %0d actual %0d",
                             $time, want.unit, assigned_index);
                    errors++;
                end
                if (none_left !== want.none)
                begin
                    $display("%0t: none_left expected %0b actual %0b",
                             $time, want.none, none_left);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 300;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0)
                burst_left = $urandom_range(1, 11);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("parallel_subplan_dispatcher_test: errors");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic dv,
                                input logic [IDX_W-1:0] di, output grant_t g);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 11);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        command <= cmd;
        done_valid <= dv;
        done_index <= di;
        do @(posedge clk); while (req_stall);
        g = grant_for_request(cmd, dv, di);
        expected_grants.push_back(g);
        items_sent++;
    endtask

    task automatic wait_idle(input int settle);
        req_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_UNIT_COUNT:     cfg_unit_count = val[6:0];
            CFG_USE_VALID_MASK: cfg_use_mask = val[0];
            CFG_VALID_MASK:     cfg_mask = val;
            CFG_FIRST_PARTIAL:  cfg_first_partial = val[6:0];
            CFG_LEADER:         cfg_leader = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [6:0] count, input logic use_mask,
                                  input logic [63:0] mask, input logic [6:0] first_partial,
                                  input logic leader);
        wait_idle(4);
        write_register(CFG_UNIT_COUNT, 64'(count));
        write_register(CFG_USE_VALID_MASK, 64'(use_mask));
        write_register(CFG_VALID_MASK, mask);
        write_register(CFG_FIRST_PARTIAL, 64'(first_partial));
        write_register(CFG_LEADER, 64'(leader));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_noise(input int count);
        grant_t g;
        repeat (count)
            send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         IDX_W'($urandom_range(0, 63)), g);
    endtask

    task automatic run_worker_round();
        int workers;
        int held[8];
        bit idle[8];
        int active;
        int w;
        int n;
        grant_t g;
        logic [1:0] cmd;
        workers = $urandom_range(1, 8);
        active = workers;
        n = 0;
        for (w = 0; w < 8; w++)
        begin
            held[w] = -1;
            idle[w] = 1'b0;
        end
        if ($urandom_range(0, 9) != 0)
            send_request(CMD_CLEAR, 1'($urandom_range(0, 1)),
                         IDX_W'($urandom_range(0, 63)), g);
        while (active > 0 && n < 90)
        begin
            w = $urandom_range(0, workers - 1);
            if (!idle[w])
            begin
                cmd = (w == 0 && workers > 1) ? CMD_LEADER : CMD_WORKER;
                if (held[w] >= 0)
                    send_request(cmd, 1'b1, held[w][IDX_W-1:0], g);
                else
                    send_request(cmd, 1'b0, IDX_W'($urandom_range(0, 63)), g);
                n++;
                if (g.none)
                begin
                    idle[w] = 1'b1;
                    held[w] = -1;
                    active--;
                end
                else
                    held[w] = int'(g.unit);
            end
        end
    endtask

    task automatic test_after_reset();
        grant_t g;
        send_request(CMD_WORKER, 1'b0, 6'd0, g);
        send_request(CMD_WORKER, 1'b1, 6'd63, g);
        send_request(CMD_CLEAR, 1'b1, 6'd21, g);
    endtask

    task automatic test_directed_cases();
        grant_t g;
        apply_settings(7'd64, 1'b0, 64'h0, 7'd0, 1'b0);
        send_request(CMD_WORKER, 1'b0, 6'd0, g);
        send_request(CMD_WORKER, 1'b1, 6'd0, g);
        send_request(CMD_LEADER, 1'b1, 6'd1, g);
        send_request(CMD_UNUSED, 1'b1, 6'd5, g);
        send_request(CMD_WORKER, 1'b1, 6'd63, g);
        apply_settings(7'd64, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 1'b1);
        send_request(CMD_LEADER, 1'b0, 6'd42, g);
        send_request(CMD_WORKER, 1'b0, 6'd0, g);
        send_request(CMD_CLEAR, 1'b0, 6'd0, g);
        send_request(CMD_WORKER, 1'b0, 6'd0, g);
        apply_settings(7'd2, 1'b0, 64'h0, 7'd2, 1'b1);
        send_request(CMD_WORKER, 1'b0, 6'd0, g);
        send_request(CMD_LEADER, 1'b0, 6'd0, g);
        send_request(CMD_WORKER, 1'b0, 6'd0, g);
        send_request(CMD_WORKER, 1'b1, 6'd0, g);
        send_request(CMD_CLEAR, 1'b0, 6'd0, g);
        apply_settings(7'd127, 1'b1, 64'h8000_0000_0000_0001, 7'd0, 1'b0);
        send_request(CMD_WORKER, 1'b0, 6'd0, g);
        send_request(CMD_WORKER, 1'b0, 6'd0, g);
        send_request(CMD_WORKER, 1'b1, 6'd0, g);
        send_request(CMD_WORKER, 1'b1, 6'd63, g);
        send_request(CMD_CLEAR, 1'b0, 6'd0, g);
        apply_settings(7'd1, 1'b1, 64'h0, 7'd127, 1'b1);
        send_request(CMD_WORKER, 1'b0, 6'd0, g);
    endtask

    task automatic test_backpressure();
        grant_t g;
        apply_settings(7'd16, 1'b0, 64'h0, 7'd0, 1'b1);
        send_request(CMD_CLEAR, 1'b0, 6'd0, g);
        hold_request = 1'b1;
        send_noise(12);
        wait_idle(0);
        run_worker_round();
    endtask

    task automatic pick_settings();
        logic [6:0]  count;
        logic [63:0] mask;
        logic [6:0]  first_partial;
        case ($urandom_range(0, 9))
            0: count = 7'd0;
            1: count = 7'd1;
            2: count = 7'd2;
            3: count = 7'd64;
            4: count = 7'd127;
            5: count = 7'($urandom_range(65, 127));
            default: count = 7'($urandom_range(3, 16));
        endcase
        case ($urandom_range(0, 3))
            0: mask = '1;
            1: mask = '0;
            2: mask = {$urandom, $urandom};
            default: mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 4))
            0: first_partial = 7'd0;
            1: first_partial = count;
            2: first_partial = 7'd127;
            3: first_partial = 7'($urandom_range(0, 127));
            default: first_partial = 7'($urandom_range(0, count));
        endcase
        apply_settings(count, 1'($urandom_range(0, 1)), mask, first_partial,
                       1'($urandom_range(0, 1)));
    endtask

    task automatic run_phases(input int target);
        while (items_sent < target)
        begin
            pick_settings();
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 4) != 0)
                    run_worker_round();
                else
                    send_noise($urandom_range(3, 15));
            end
        end
    endtask

    task automatic test_random_phases();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            run_phases(items_sent + 100);
        end
    endtask

    task automatic test_final_quiet();
        quiet = 1'b1;
        run_phases(items_sent + QUIET_ITEMS);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_directed_cases();
        test_backpressure();
        test_random_phases();
        test_final_quiet();
        wait_idle(DRAIN_CYCLES);
        if (errors == 0)
            $display("parallel_subplan_dispatcher_test: clean");
        else
            $display("parallel_subplan_dispatcher_test: errors");
        $finish;
    end

endmodule
